FILE: hw/rtl/lgs_pkg.sv
// Shared constants and types for the life generation stencil.
package lgs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;

  // Width of the size registers and of the row counter (holds MAX_HEIGHT + 1).
  localparam int SIZE_W = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);

  // One window column: bit 0 top, bit 1 middle, bit 2 bottom.
  localparam int WIN_H = 3;

  // Register indexes on the configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  typedef logic [WIN_H-1:0] win_col_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/lgs_ram.sv
// Generic simple dual-port RAM with registered read.
module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/lgs_cell.sv
// One column cell of the 3x3 window chain.
module lgs_cell (
  input  logic               clk,
  input  logic               rst,
  input  lgs_pkg::cell_ctl_t ctl,
  input  lgs_pkg::win_col_t  din,
  output lgs_pkg::win_col_t  dout
);

  lgs_pkg::win_col_t column;

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (ctl.clear) begin
      column <= '0;
    end else if (ctl.shift) begin
      column <= din;
    end
  end

  assign dout = column;

endmodule

FILE: hw/rtl/life_generation_stencil.sv
// Top level: streaming B3/S23 generation step over a raster cell grid.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one cell per request in raster
//   order: cell_alive, plus flush to mark padding. After each frame the
//   source sends grid_width+1 flush requests to drain the last row.
//   Output channel (out_valid / out_stall) gives next_alive for each cell in
//   raster order; last is set on the final cell of the generation.
//   Throughput: one cell per cycle while the receiver does not stall. The
//   line store is a single registered-read RAM; a read is issued at acceptance
//   and the write-back happens as the window stage moves on, so one RAM port
//   pair carries one cell a cycle. A request's result enters the output
//   register as the window stage passes it on; in frame terms a cell's result
//   appears once the request one row and one cell later has been accepted.
//   The first grid_width+1 requests of a frame produce no result.
//   Receiver stall: the output register holds; at most one more request waits
//   in the window stage, and in_stall stays high until the output drains.
//   Reset: sizes return to 8x8, position and window clear. The line store
//   needs no clearing pass: rows above the top of the grid are gated dead.
//   Configuration writes (only while idle) restart the frame.
module life_generation_stencil (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [lgs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lgs_pkg::SIZE_W-1:0]          cfg_data,
  // input cells
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cell_alive,
  input  logic                                flush,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                next_alive,
  output logic                                last
);

  localparam int SIZE_W = lgs_pkg::SIZE_W;
  localparam int COL_W  = lgs_pkg::COL_W;

  // Saturate a size register to [MIN_SIZE, hi].
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] r;
    if (v < SIZE_W'(lgs_pkg::MIN_SIZE)) r = SIZE_W'(lgs_pkg::MIN_SIZE);
    else if (v > hi)                    r = hi;
    else                                r = v;
    return r;
  endfunction

  function automatic logic [1:0] pop3(input lgs_pkg::win_col_t v);
    return 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
  endfunction

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(8);
      grid_height <= SIZE_W'(8);
    end else if (cfg_write) begin
      unique case (cfg_index)
        lgs_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        lgs_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_size(grid_width,  SIZE_W'(lgs_pkg::MAX_WIDTH));
  assign h_eff = clamp_size(grid_height, SIZE_W'(lgs_pkg::MAX_HEIGHT));

  // ---------------------------------------------------------------
  // Input position (column, row of the next request)
  // ---------------------------------------------------------------
  logic [COL_W-1:0]  col;
  logic [SIZE_W-1:0] row;
  logic              in_fire;
  logic              col_wrap;
  logic              item_last;
  logic              item_emit;
  logic              item_x;

  assign in_fire   = in_valid && !in_stall;
  assign col_wrap  = ({1'b0, col} == w_eff - SIZE_W'(1));
  // Final result comes with the request at row H+1, column 0.
  assign item_last = (row == h_eff + SIZE_W'(1)) && (col == '0);
  assign item_emit = (row >= SIZE_W'(2)) || ((row == SIZE_W'(1)) && (col != '0));
  // Flush and rows below the grid read as dead.
  assign item_x    = cell_alive && !flush && (row < h_eff);

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (item_last) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + SIZE_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------
  // Window stage: registers the request alongside the line store read
  // ---------------------------------------------------------------
  logic             a_valid;
  logic             a_x;
  logic             a_top_ok;
  logic             a_mid_ok;
  logic             a_col0;
  logic             a_emit;
  logic             a_last;
  logic [COL_W-1:0] a_col;
  logic             a_move;

  assign a_move   = a_valid && (!a_emit || !out_valid || !out_stall);
  assign in_stall = a_valid && !a_move;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_x      <= item_x;
      a_top_ok <= (row >= SIZE_W'(2));
      a_mid_ok <= (row >= SIZE_W'(1));
      a_col0   <= (col == '0);
      a_emit   <= item_emit;
      a_last   <= item_last;
      a_col    <= col;
    end
  end

  // ---------------------------------------------------------------
  // Line store: bit 1 holds the row two above, bit 0 the row above.
  // A held window stage keeps re-reading its own column.
  // ---------------------------------------------------------------
  logic [COL_W-1:0] ram_raddr;
  logic [1:0]       ram_rdata;
  logic [1:0]       ram_wdata;
  logic             top_bit;
  logic             mid_bit;
  lgs_pkg::win_col_t new_col;

  assign ram_raddr = in_stall ? a_col : col;
  assign top_bit   = a_top_ok && ram_rdata[1];
  assign mid_bit   = a_mid_ok && ram_rdata[0];
  assign new_col   = {a_x, mid_bit, top_bit};
  assign ram_wdata = {mid_bit, a_x};

  lgs_ram #(
    .WIDTH(2),
    .DEPTH(lgs_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (a_move),
    .waddr(a_col),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // ---------------------------------------------------------------
  // Window chain: three column cells. At column 0 the previous row is
  // finished against a dead right edge and the left cells are cleared.
  // ---------------------------------------------------------------
  lgs_pkg::cell_ctl_t win_ctl;
  lgs_pkg::win_col_t  win [3];
  lgs_pkg::win_col_t  win_din [3];

  assign win_ctl.shift = a_move;
  assign win_ctl.clear = cfg_write || (a_move && a_last);

  assign win_din[0] = a_col0 ? '0 : win[1];
  assign win_din[1] = a_col0 ? '0 : win[2];
  assign win_din[2] = new_col;

  for (genvar i = 0; i < 3; i++) begin : g_cell
    lgs_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (win_ctl),
      .din (win_din[i]),
      .dout(win[i])
    );
  end

  // Neighborhood: left = win[1], center column = win[2], right = new column.
  lgs_pkg::win_col_t right_col;
  logic              center;
  logic [3:0]        count;
  logic              rule_out;

  assign right_col = a_col0 ? '0 : new_col;
  assign center    = win[2][1];
  assign count     = 4'(pop3(win[1])) + 4'(pop3(win[2])) + 4'(pop3(right_col))
                     - 4'(center);
  assign rule_out  = center ? ((count == 4'd2) || (count == 4'd3)) : (count == 4'd3);

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move && a_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move && a_emit) begin
      next_alive <= rule_out;
      last       <= a_last;
    end
  end

`ifndef SYNTHESIS
  // Write-back never hits the column being read, except the frame restart.
  a_ram_no_collide: assert property (@(posedge clk) disable iff (rst)
    a_move && !a_last |-> a_col != ram_raddr)
    else $error("line store write collides with read");

  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    a_move && a_emit |=> out_valid)
    else $error("result lost at output register");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col} < w_eff)
    else $error("column beyond grid width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row <= h_eff + SIZE_W'(1))
    else $error("row beyond drain row");
`endif

endmodule

FILE: test/tb_life_generation_stencil.sv
// Self-checking testbench for the streaming B3/S23 generation stencil.
`timescale 1ns / 1ps

module tb_life_generation_stencil;

  localparam int SIZE_W      = lgs_pkg::SIZE_W;
  localparam int CFG_INDEX_W = lgs_pkg::CFG_INDEX_W;
  localparam int MAX_WIDTH   = lgs_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = lgs_pkg::MAX_HEIGHT;
  localparam int MIN_SIZE    = lgs_pkg::MIN_SIZE;

  localparam int SETTLE_CYCLES = 8;     // window stage plus output register, with margin
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD     = 300;   // receiver hold-off used to back up the pipe
  localparam int PHASE_ITEMS   = 250;   // random requests per idling phase

  // Directed 3x3 frame: a horizontal bar in the middle row, bit k is raster cell k.
  // The middle cell of the bar is also marked as padding inside the frame.
  localparam logic [8:0] BAR_CELLS = 9'b000_111_000;
  localparam logic [8:0] BAR_FLUSH = 9'b000_010_000;

  typedef struct packed {
    logic alive;
    logic pad;
  } cell_req_t;

  typedef struct packed {
    logic next_alive;
    logic last;
  } cell_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                   clk        = 1'b0;
  logic                   rst        = 1'b1;
  logic                   cfg_write  = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index  = lgs_pkg::REG_GRID_WIDTH;
  logic [SIZE_W-1:0]      cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   cell_alive = 1'b0;
  logic                   flush      = 1'b0;
  logic                   out_stall  = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic                   next_alive;
  logic                   last;

  life_generation_stencil dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cell_alive (cell_alive),
    .flush      (flush),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_alive (next_alive),
    .last       (last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus and scoreboard storage
  // ---------------------------------------------------------------------------
  cell_req_t    cell_feed_q[$];   // requests waiting to be offered
  cell_result_t next_gen_q[$];    // predicted next-generation cells, oldest first

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;         // long receiver hold-off, counted down by the stall process

  int items_queued    = 0;
  int frames_queued   = 0;
  int cfg_writes      = 0;
  int results_checked = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;

  // used sizes, as the stimulus side sees them
  int unsigned cur_w = 8;
  int unsigned cur_h = 8;

  // ---------------------------------------------------------------------------
  // Generation predictor: own copy of the line stores, window and position
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0]    width_reg  = 11'd8;
  logic [SIZE_W-1:0]    height_reg = 11'd8;
  bit   [MAX_WIDTH-1:0] upper_row;      // row two above the input row
  bit   [MAX_WIDTH-1:0] middle_row;     // row just above the input row
  lgs_pkg::win_col_t    nbhd_cols[3];   // left, center, right columns of the window
  int unsigned          feed_col;
  int unsigned          feed_row;
  int unsigned          cells_out;      // results given so far in this frame

  // Register values saturate to [MIN_SIZE, hi].
  function automatic int unsigned size_in_use(logic [SIZE_W-1:0] raw, int unsigned hi);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  function automatic void restart_frame_state();
    feed_col  = 0;
    feed_row  = 0;
    cells_out = 0;
    for (int k = 0; k < 3; k++) nbhd_cols[k] = '0;
  endfunction

  // Take one cell request; queue the next-generation cell it completes, if any.
  function automatic void step_generation(logic alive, logic pad);
    int unsigned       w, h, c, r, ctr, cnt;
    logic              x, top, mid;
    lgs_pkg::win_col_t nc, a, b, cc;
    bit                emit;
    cell_result_t      res;
    w = size_in_use(width_reg, MAX_WIDTH);
    h = size_in_use(height_reg, MAX_HEIGHT);
    c = feed_col;
    r = feed_row;
    if (c >= w) c = 0;
    // padding, and anything below the last row, reads as dead
    x   = alive && !pad && (r < h);
    // rows above the top of the grid are dead, whatever the stores still hold
    top = (r >= 2) ? upper_row[c] : 1'b0;
    mid = (r >= 1) ? middle_row[c] : 1'b0;
    nc  = {x, mid, top};
    upper_row[c]  = mid;
    middle_row[c] = x;
    emit = (r >= 2) || (r == 1 && c >= 1);
    if (c == 0) begin
      // close out the previous row against a dead right border
      a  = nbhd_cols[1];
      b  = nbhd_cols[2];
      cc = '0;
      nbhd_cols[0] = '0;
      nbhd_cols[1] = '0;
      nbhd_cols[2] = nc;
    end else begin
      nbhd_cols[0] = nbhd_cols[1];
      nbhd_cols[1] = nbhd_cols[2];
      nbhd_cols[2] = nc;
      a  = nbhd_cols[0];
      b  = nbhd_cols[1];
      cc = nbhd_cols[2];
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    feed_col = c;
    feed_row = r;
    if (emit) begin
      ctr = 32'(b[1]);
      cnt = $countones(a) + $countones(b) + $countones(cc) - ctr;
      res.next_alive = ctr ? (cnt == 2 || cnt == 3) : (cnt == 3);
      res.last       = (cells_out == w * h - 1);
      next_gen_q.push_back(res);
      if (res.last) restart_frame_state();
      else cells_out++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, holds the payload while stalled
  // ---------------------------------------------------------------------------
  cell_req_t offer;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // slot is free: either nothing was offered or the last request went in
      if (cell_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer = cell_feed_q.pop_front();
        in_valid   <= 1'b1;
        cell_alive <= offer.alive;
        flush      <= offer.pad;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random, or held high for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: mirrors register writes and accepted requests into the predictor,
  // then checks every accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst) begin
      width_reg  = 11'd8;
      height_reg = 11'd8;
      upper_row  = '0;
      middle_row = '0;
      restart_frame_state();
    end else begin
      if (cfg_write) begin
        if (cfg_index == lgs_pkg::REG_GRID_WIDTH) width_reg = cfg_data;
        else if (cfg_index == lgs_pkg::REG_GRID_HEIGHT) height_reg = cfg_data;
        restart_frame_state();
      end
      // predict first: a result never leaves in the cycle its request enters
      if (in_valid && !in_stall) step_generation(cell_alive, flush);
      if (out_valid && !out_stall) begin
        if (next_gen_q.size() == 0) begin
          fail_count++;
          $error("unexpected result: next_alive=%0b last=%0b", next_alive, last);
        end else begin
          want = next_gen_q.pop_front();
          results_checked++;
          if (next_alive !== want.next_alive) begin
            fail_count++;
            $error("next_alive: expected %0b, got %0b", want.next_alive, next_alive);
          end
          if (last !== want.last) begin
            fail_count++;
            $error("last: expected %0b, got %0b", want.last, last);
          end
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, next_gen_q.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait until every request is in and every result is out, then let the
  // window stage empty out (requests that give no result may still be inside).
  task automatic wait_drained();
    do @(negedge clk);
    while (cell_feed_q.size() != 0 || in_valid || next_gen_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_sizes(logic [SIZE_W-1:0] wv, logic [SIZE_W-1:0] hv);
    write_reg(lgs_pkg::REG_GRID_WIDTH, wv);
    write_reg(lgs_pkg::REG_GRID_HEIGHT, hv);
    cur_w = size_in_use(wv, MAX_WIDTH);
    cur_h = size_in_use(hv, MAX_HEIGHT);
  endtask

  // Mostly small grids; now and then a size below the minimum.
  task automatic pick_random_sizes();
    int unsigned wr, hr;
    wr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
    hr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
    set_sizes(SIZE_W'(wr), SIZE_W'(hr));
  endtask

  // Grid cells in raster order; noise_pct marks cells as padding inside the frame.
  task automatic queue_cells(int unsigned n, int live_pct, int noise_pct);
    cell_req_t req;
    @(negedge clk);
    for (int unsigned k = 0; k < n; k++) begin
      req.alive = ($urandom_range(99) < live_pct);
      req.pad   = ($urandom_range(99) < noise_pct);
      cell_feed_q.push_back(req);
    end
    items_queued += n;
  endtask

  // Whole frame plus the width+1 drain requests. Drain requests carry random
  // cell bits, and a few are not even flagged: below the grid they read dead anyway.
  task automatic queue_frame(int unsigned w, int unsigned h, int live_pct, int noise_pct);
    cell_req_t req;
    queue_cells(w * h, live_pct, noise_pct);
    for (int unsigned k = 0; k <= w; k++) begin
      req.alive = 1'($urandom_range(1));
      req.pad   = ($urandom_range(7) != 0);
      cell_feed_q.push_back(req);
    end
    items_queued += w + 1;
    frames_queued++;
  endtask

  // Random frames under one idling pattern. Sizes change now and then, and
  // some frames are cut short and restarted by a size write.
  task automatic run_phase(int idle_pct, int stall_pct, int quota);
    int start, pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_queued;
    while (items_queued - start < quota) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        wait_drained();
        pick_random_sizes();
      end
      if (pick >= 92) begin
        queue_cells($urandom_range(1, cur_w * cur_h), $urandom_range(100), 0);
        wait_drained();
        pick_random_sizes();
      end else begin
        // back-to-back frames with no pause check the restart after the last cell
        queue_frame(cur_w, cur_h, $urandom_range(100), ($urandom_range(9) == 0) ? 15 : 0);
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    cell_req_t req;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: a cut-off all-live frame at the reset size (8x8). Its first
    // results come from rows 0 and 1; the size write after it restarts the frame.
    queue_cells(12, 100, 0);
    wait_drained();

    // Directed: sizes below the minimum saturate to 3x3. Bar pattern with a
    // padding flag on a live cell inside the frame, and live drain requests,
    // one of them not flagged.
    set_sizes(11'd0, 11'd2);
    @(negedge clk);
    for (int k = 0; k < 9; k++) begin
      req.alive = BAR_CELLS[k];
      req.pad   = BAR_FLUSH[k];
      cell_feed_q.push_back(req);
    end
    for (int k = 0; k < 4; k++) begin
      req.alive = 1'b1;
      req.pad   = (k != 2);
      cell_feed_q.push_back(req);
    end
    items_queued += 13;
    frames_queued++;
    wait_drained();

    // Random frames under each idling pattern.
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(74, 0, PHASE_ITEMS);
    run_phase(0, 74, PHASE_ITEMS);
    run_phase(36, 36, PHASE_ITEMS);

    // Back-pressure: the receiver holds off while the sender keeps offering,
    // so the block fills and stalls its input.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_sizes(11'd16, 11'd12);
    queue_frame(cur_w, cur_h, 40, 0);
    hold_left = LONG_HOLD;
    wait_drained();
    // sender paused above until everything drained; next frame, same sizes
    queue_frame(cur_w, cur_h, 35, 5);
    wait_drained();

    // tail: anything that shows up now has no prediction and is flagged
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d cell requests in %0d frames over %0d size writes.",
             items_queued, frames_queued, cfg_writes);
    $display("Checked %0d next-generation cells, %0d mismatches.",
             results_checked, fail_count);
    if (fail_count == 0 && next_gen_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
